/* rtl/chip8_instruction_core_assert.svh */
// Assertion macros for the CHIP-8 instruction core
`ifndef CHIP8_INSTRUCTION_CORE_ASSERT_SVH
`define CHIP8_INSTRUCTION_CORE_ASSERT_SVH
`ifndef SYNTH
`define C8IC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("chip8 core check failed");
`define C8IC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chip8 core sequence check failed");
`else
`define C8IC_ASSERT(lbl, prop)
`define C8IC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/c8ic_pkg.sv */
// Shared types, opcodes and tables of the CHIP-8 instruction core
`timescale 1ns / 1ps
package c8ic_pkg;

  localparam int MEM_DEPTH           = 4096;
  localparam int MEM_AW              = 12;
  localparam int STACK_DEPTH_DEFAULT = 16;
  localparam int FONT_LEN            = 80;
  localparam logic [MEM_AW-1:0] START_RESET = 12'h200;

  typedef enum logic [1:0] {
    CMD_EXEC = 2'd0,
    CMD_TICK = 2'd1,
    CMD_LOAD = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_BADOP = 2'd1,
    STS_OVF   = 2'd2,
    STS_UNF   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MISC,
    ST_FETCH_HI,
    ST_FETCH_LO,
    ST_DECODE,
    ST_READ_Y,
    ST_EXEC,
    ST_WR_X,
    ST_BCD_T,
    ST_BCD_O,
    ST_BLK_RD,
    ST_BLK_WR,
    ST_FIN
  } state_t;

  // Major opcode nybbles
  localparam logic [3:0] OPC_SYS  = 4'h0;
  localparam logic [3:0] OPC_JP   = 4'h1;
  localparam logic [3:0] OPC_CALL = 4'h2;
  localparam logic [3:0] OPC_SEI  = 4'h3;
  localparam logic [3:0] OPC_SNEI = 4'h4;
  localparam logic [3:0] OPC_SER  = 4'h5;
  localparam logic [3:0] OPC_LDI  = 4'h6;
  localparam logic [3:0] OPC_ADDI = 4'h7;
  localparam logic [3:0] OPC_ALU  = 4'h8;
  localparam logic [3:0] OPC_SNER = 4'h9;
  localparam logic [3:0] OPC_LDIX = 4'hA;
  localparam logic [3:0] OPC_JPV0 = 4'hB;
  localparam logic [3:0] OPC_RND  = 4'hC;
  localparam logic [3:0] OPC_DRW  = 4'hD;
  localparam logic [3:0] OPC_KEY  = 4'hE;

  // ALU sub-operations of 8XYN
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_RSB = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  // Low-byte sub-operations
  localparam logic [7:0] NN_CLS   = 8'hE0;
  localparam logic [7:0] NN_RET   = 8'hEE;
  localparam logic [7:0] NN_SKP   = 8'h9E;
  localparam logic [7:0] NN_SKNP  = 8'hA1;
  localparam logic [7:0] NN_GDT   = 8'h07;
  localparam logic [7:0] NN_WKEY  = 8'h0A;
  localparam logic [7:0] NN_SDT   = 8'h15;
  localparam logic [7:0] NN_SST   = 8'h18;
  localparam logic [7:0] NN_ADDIX = 8'h1E;
  localparam logic [7:0] NN_FONT  = 8'h29;
  localparam logic [7:0] NN_BCD   = 8'h33;
  localparam logic [7:0] NN_STORE = 8'h55;
  localparam logic [7:0] NN_LOAD  = 8'h65;

  localparam logic [7:0] FONT [FONT_LEN] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic [MEM_AW-1:0] raddr;
  } pm_req_t;

endpackage

/* rtl/chip8_instruction_core.sv */
// CHIP-8 instruction core top level: stream ports, APB register and sequencer
`timescale 1ns / 1ps
// CHIP-8 interpreter core. Each input transfer carries one command: execute the
// instruction at PC, tick the delay and sound timers, or store one byte into the
// 4 KiB program memory; each command yields exactly one result transfer. Program
// memory and the register file (V0..VF plus the return stack) are synchronous
// RAMs with registered reads, and every instruction is a fixed sequence of reads
// and write-backs through their one read and one write port each. After reset
// the core sweeps the font and zeros into program memory and holds s_axis_tready
// low until done; the start address register may be written meanwhile. Writing
// start_address also loads PC. Drawing is not done here: DXYN reports Vx-1, Vy,
// I and N on the result and takes the collision flag from the input. Stack
// overflow and underflow are reported and otherwise ignored.
`include "chip8_instruction_core_assert.svh"
module chip8_instruction_core #(
  parameter int STACK_DEPTH = c8ic_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // key_mask[15:0], pressed_key[19:16], random_byte[27:20], draw_collision[28],
  // load_address[40:29], load_data[48:41], zero pad [55:49]
  input  logic [55:0] s_axis_tdata,
  // command[1:0]
  input  logic [1:0]  s_axis_tuser,
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pc[11:0], status[13:12], clear_screen[14], draw_request[15], draw_x[23:16],
  // draw_y[31:24], draw_address[43:32], draw_rows[47:44], sound_on[48],
  // key_wait[49], zero pad [55:50]
  output logic [55:0] m_axis_tdata
);
  import c8ic_pkg::*;

  localparam int RF_AW = $clog2(16 + STACK_DEPTH);
  localparam int SPW   = $clog2(STACK_DEPTH + 1);

  // Control state
  state_t              state, state_next;
  logic [MEM_AW-1:0]   start_address, start_address_next;
  logic [MEM_AW-1:0]   pc, pc_next;
  logic [15:0]         idx, idx_next;
  logic [SPW-1:0]      sp, sp_next;
  logic [7:0]          dt, dt_next;
  logic [7:0]          st, st_next;
  logic                out_valid, out_valid_next;

  // Payload held over an item
  cmd_t                cmd;
  logic [15:0]         keys;
  logic [3:0]          pkey;
  logic [7:0]          rnd;
  logic                coll;
  logic [MEM_AW-1:0]   laddr;
  logic [7:0]          ldata;
  logic [7:0]          op_hi, op_hi_next;
  logic [7:0]          op_lo, op_lo_next;
  logic [11:0]         va, va_next;
  logic [7:0]          wres, wres_next;
  logic [3:0]          cnt, cnt_next;
  logic [6:0]          bcd_r, bcd_r_next;
  logic [3:0]          bcd_o, bcd_o_next;
  status_t             res_status, res_status_next;
  logic                res_cls, res_cls_next;
  logic                res_draw, res_draw_next;
  logic [7:0]          res_dx, res_dx_next;
  logic [7:0]          res_dy, res_dy_next;
  logic [MEM_AW-1:0]   res_da, res_da_next;
  logic [3:0]          res_dn, res_dn_next;
  logic                res_kw, res_kw_next;
  logic                in_take;
  logic                out_load;

  // Memory ports
  pm_req_t             pm_req;
  logic [7:0]          pm_rdata;
  logic                pm_ready;
  logic                rf_we;
  logic [RF_AW-1:0]    rf_waddr;
  logic [11:0]         rf_wdata;
  logic [RF_AW-1:0]    rf_raddr;
  logic [11:0]         rf_rdata;

  // Decode helpers
  logic [3:0]          fx;
  logic [3:0]          fy;
  logic [3:0]          fn;
  logic [11:0]         nnn;
  logic [7:0]          vx;
  logic [7:0]          vy;
  logic                flag;
  logic [7:0]          vxf;
  logic [7:0]          vyf;
  logic                held;
  logic [13:0]         h_prod;
  logic [1:0]          hund;
  logic [13:0]         t_prod;
  logic [3:0]          tens;
  logic                cfg_wr;

  c8ic_pmem u_pmem (
    .clk   (clk),
    .rst   (rst),
    .req   (pm_req),
    .rdata (pm_rdata),
    .ready (pm_ready)
  );

  c8ic_rf #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_rf (
    .clk   (clk),
    .rst   (rst),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  // APB: one register, word aligned; pready tied high
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'h0 : {20'h0, start_address};

  assign s_axis_tready = (state == ST_IDLE) && pm_ready;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;

  // Instruction fields
  assign fx  = op_hi[3:0];
  assign fy  = op_lo[7:4];
  assign fn  = op_lo[3:0];
  assign nnn = {op_hi[3:0], op_lo};
  assign vx  = va[7:0];
  assign vy  = rf_rdata[7:0];

  // VF is written before the result is formed, so forward the flag into an
  // operand that names VF
  always_comb begin
    case (fn)
      ALU_ADD: flag = ({1'b0, vx} + {1'b0, vy}) > 9'd255;
      ALU_SUB: flag = !(vy > vx);
      ALU_SHR: flag = vy[0];
      ALU_RSB: flag = !(vx > vy);
      ALU_SHL: flag = vy[7];
      default: flag = 1'b0;
    endcase
  end
  assign vxf = (fx == 4'hF) ? {7'h00, flag} : vx;
  assign vyf = (fy == 4'hF) ? {7'h00, flag} : vy;

  assign held = (vx[7:4] == 4'h0) && keys[vx[3:0]];

  // Decimal digits by reciprocal multiplication: exact over 0..255
  assign h_prod = 14'(vx) * 14'd41;
  assign hund   = h_prod[13:12];
  assign t_prod = 14'(bcd_r) * 14'd103;
  assign tens   = t_prod[13:10];

  always_comb begin
    state_next         = state;
    start_address_next = start_address;
    pc_next            = pc;
    idx_next           = idx;
    sp_next            = sp;
    dt_next            = dt;
    st_next            = st;
    out_valid_next     = out_valid;
    op_hi_next         = op_hi;
    op_lo_next         = op_lo;
    va_next            = va;
    wres_next          = wres;
    cnt_next           = cnt;
    bcd_r_next         = bcd_r;
    bcd_o_next         = bcd_o;
    res_status_next    = res_status;
    res_cls_next       = res_cls;
    res_draw_next      = res_draw;
    res_dx_next        = res_dx;
    res_dy_next        = res_dy;
    res_da_next        = res_da;
    res_dn_next        = res_dn;
    res_kw_next        = res_kw;
    out_load           = 1'b0;
    pm_req             = '0;
    rf_we              = 1'b0;
    rf_waddr           = RF_AW'(fx);
    rf_wdata           = 12'h000;
    rf_raddr           = RF_AW'(fx);

    // Drop a result once taken
    if (out_valid && m_axis_tready) begin
      out_valid_next = 1'b0;
    end

    if (cfg_wr) begin
      start_address_next = pwdata[MEM_AW-1:0];
      pc_next            = pwdata[MEM_AW-1:0];
    end

    case (state)
      ST_IDLE: begin
        if (in_take) begin
          res_status_next = STS_OK;
          res_cls_next    = 1'b0;
          res_draw_next   = 1'b0;
          res_dx_next     = 8'h00;
          res_dy_next     = 8'h00;
          res_da_next     = '0;
          res_dn_next     = 4'h0;
          res_kw_next     = 1'b0;
          state_next = (cmd_t'(s_axis_tuser) == CMD_EXEC) ? ST_FETCH_HI : ST_MISC;
        end
      end
      ST_MISC: begin
        if (cmd == CMD_TICK) begin
          if (dt != 8'h00) dt_next = dt - 8'd1;
          if (st != 8'h00) st_next = st - 8'd1;
        end else if (cmd == CMD_LOAD) begin
          pm_req.we    = 1'b1;
          pm_req.waddr = laddr;
          pm_req.wdata = ldata;
        end
        state_next = ST_FIN;
      end
      ST_FETCH_HI: begin
        pm_req.raddr = pc;
        state_next   = ST_FETCH_LO;
      end
      ST_FETCH_LO: begin
        pm_req.raddr = pc + 12'd1;
        op_hi_next   = pm_rdata;
        state_next   = ST_DECODE;
      end
      ST_DECODE: begin
        op_lo_next = pm_rdata;
        pc_next    = pc + 12'd2;
        // First operand: top of stack for a return, V0 for BNNN, else Vx
        case (op_hi[7:4])
          OPC_SYS:  rf_raddr = RF_AW'(16) + RF_AW'(sp) - RF_AW'(1);
          OPC_JPV0: rf_raddr = '0;
          default:  rf_raddr = RF_AW'(op_hi[3:0]);
        endcase
        state_next = ST_READ_Y;
      end
      ST_READ_Y: begin
        va_next    = rf_rdata;
        rf_raddr   = RF_AW'(fy);
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_FIN;
        case (op_hi[7:4])
          OPC_SYS: begin
            if (op_lo == NN_CLS) begin
              res_cls_next = 1'b1;
            end else if (op_lo == NN_RET) begin
              if (sp == '0) begin
                res_status_next = STS_UNF;
              end else begin
                sp_next = sp - SPW'(1);
                pc_next = va;
              end
            end else begin
              res_status_next = STS_BADOP;
            end
          end
          OPC_JP: pc_next = nnn;
          OPC_CALL: begin
            if (sp < SPW'(STACK_DEPTH)) begin
              rf_we    = 1'b1;
              rf_waddr = RF_AW'(16) + RF_AW'(sp);
              rf_wdata = pc;
              sp_next  = sp + SPW'(1);
              pc_next  = nnn;
            end else begin
              res_status_next = STS_OVF;
            end
          end
          OPC_SEI:  if (vx == op_lo) pc_next = pc + 12'd2;
          OPC_SNEI: if (vx != op_lo) pc_next = pc + 12'd2;
          OPC_SER:  if (vx == vy) pc_next = pc + 12'd2;
          OPC_SNER: if (vx != vy) pc_next = pc + 12'd2;
          OPC_LDI: begin
            rf_we    = 1'b1;
            rf_wdata = {4'h0, op_lo};
          end
          OPC_ADDI: begin
            rf_we    = 1'b1;
            rf_wdata = {4'h0, vx + op_lo};
          end
          OPC_ALU: begin
            case (fn)
              ALU_MOV: begin rf_we = 1'b1; rf_wdata = {4'h0, vy}; end
              ALU_OR:  begin rf_we = 1'b1; rf_wdata = {4'h0, vx | vy}; end
              ALU_AND: begin rf_we = 1'b1; rf_wdata = {4'h0, vx & vy}; end
              ALU_XOR: begin rf_we = 1'b1; rf_wdata = {4'h0, vx ^ vy}; end
              ALU_ADD, ALU_SUB, ALU_SHR, ALU_RSB, ALU_SHL: begin
                // Flag now, result next cycle
                rf_we    = 1'b1;
                rf_waddr = RF_AW'(15);
                rf_wdata = {11'h000, flag};
                case (fn)
                  ALU_ADD: wres_next = vxf + vyf;
                  ALU_SUB: wres_next = vxf - vyf;
                  ALU_SHR: wres_next = vyf >> 1;
                  ALU_RSB: wres_next = vyf - vxf;
                  default: wres_next = vyf << 1;
                endcase
                state_next = ST_WR_X;
              end
              default: res_status_next = STS_BADOP;
            endcase
          end
          OPC_LDIX: idx_next = {4'h0, nnn};
          OPC_JPV0: pc_next = nnn + {4'h0, vx};
          OPC_RND: begin
            rf_we    = 1'b1;
            rf_wdata = {4'h0, rnd & op_lo};
          end
          OPC_DRW: begin
            res_draw_next = 1'b1;
            res_dx_next   = vx - 8'd1;
            res_dy_next   = vy;
            res_da_next   = idx[MEM_AW-1:0];
            res_dn_next   = fn;
            rf_we         = 1'b1;
            rf_waddr      = RF_AW'(15);
            rf_wdata      = {11'h000, coll};
          end
          OPC_KEY: begin
            if (op_lo == NN_SKP) begin
              if (held) pc_next = pc + 12'd2;
            end else if (op_lo == NN_SKNP) begin
              if (!held) pc_next = pc + 12'd2;
            end else begin
              res_status_next = STS_BADOP;
            end
          end
          default: begin
            case (op_lo)
              NN_GDT: begin
                rf_we    = 1'b1;
                rf_wdata = {4'h0, dt};
              end
              NN_WKEY: begin
                rf_we       = 1'b1;
                rf_wdata    = {8'h00, pkey};
                res_kw_next = 1'b1;
              end
              NN_SDT:   dt_next  = vx;
              NN_SST:   st_next  = vx;
              NN_ADDIX: idx_next = idx + {8'h00, vx};
              NN_FONT:  idx_next = {6'h00, vx, 2'b00} + {8'h00, vx};
              NN_BCD: begin
                pm_req.we    = 1'b1;
                pm_req.waddr = idx[MEM_AW-1:0];
                pm_req.wdata = {6'h00, hund};
                bcd_r_next   = 7'(vx - 8'(hund) * 8'd100);
                state_next   = ST_BCD_T;
              end
              NN_STORE, NN_LOAD: begin
                cnt_next   = 4'h0;
                state_next = ST_BLK_RD;
              end
              default: res_status_next = STS_BADOP;
            endcase
          end
        endcase
      end
      ST_WR_X: begin
        rf_we      = 1'b1;
        rf_wdata   = {4'h0, wres};
        state_next = ST_FIN;
      end
      ST_BCD_T: begin
        pm_req.we    = 1'b1;
        pm_req.waddr = idx[MEM_AW-1:0] + 12'd1;
        pm_req.wdata = {4'h0, tens};
        bcd_o_next   = 4'(bcd_r - 7'(tens) * 7'd10);
        state_next   = ST_BCD_O;
      end
      ST_BCD_O: begin
        pm_req.we    = 1'b1;
        pm_req.waddr = idx[MEM_AW-1:0] + 12'd2;
        pm_req.wdata = {4'h0, bcd_o};
        state_next   = ST_FIN;
      end
      ST_BLK_RD: begin
        rf_raddr     = RF_AW'(cnt);
        pm_req.raddr = idx[MEM_AW-1:0];
        state_next   = ST_BLK_WR;
      end
      ST_BLK_WR: begin
        if (op_lo == NN_STORE) begin
          pm_req.we    = 1'b1;
          pm_req.waddr = idx[MEM_AW-1:0];
          pm_req.wdata = rf_rdata[7:0];
        end else begin
          rf_we    = 1'b1;
          rf_waddr = RF_AW'(cnt);
          rf_wdata = {4'h0, pm_rdata};
        end
        idx_next = idx + 16'd1;
        if (cnt == fx) begin
          state_next = ST_FIN;
        end else begin
          cnt_next   = cnt + 4'd1;
          state_next = ST_BLK_RD;
        end
      end
      ST_FIN: begin
        // Hold until the output register is free
        if (!out_valid || m_axis_tready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      start_address <= START_RESET;
      pc            <= START_RESET;
      idx           <= '0;
      sp            <= '0;
      dt            <= '0;
      st            <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      start_address <= start_address_next;
      pc            <= pc_next;
      idx           <= idx_next;
      sp            <= sp_next;
      dt            <= dt_next;
      st            <= st_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd   <= cmd_t'(s_axis_tuser);
      keys  <= s_axis_tdata[15:0];
      pkey  <= s_axis_tdata[19:16];
      rnd   <= s_axis_tdata[27:20];
      coll  <= s_axis_tdata[28];
      laddr <= s_axis_tdata[40:29];
      ldata <= s_axis_tdata[48:41];
    end
    op_hi      <= op_hi_next;
    op_lo      <= op_lo_next;
    va         <= va_next;
    wres       <= wres_next;
    cnt        <= cnt_next;
    bcd_r      <= bcd_r_next;
    bcd_o      <= bcd_o_next;
    res_status <= res_status_next;
    res_cls    <= res_cls_next;
    res_draw   <= res_draw_next;
    res_dx     <= res_dx_next;
    res_dy     <= res_dy_next;
    res_da     <= res_da_next;
    res_dn     <= res_dn_next;
    res_kw     <= res_kw_next;
    if (out_load) begin
      m_axis_tdata <= {6'h00, res_kw, (st != 8'h00), res_dn, res_da, res_dy, res_dx,
                       res_draw, res_cls, res_status, pc};
    end
  end

  `C8IC_ASSERT_NEXT(a_accept_leaves_idle, in_take, state != ST_IDLE)
  `C8IC_ASSERT(a_sp_bound, sp <= SPW'(STACK_DEPTH))
  `C8IC_ASSERT(a_result_from_fin, $rose(m_axis_tvalid) |-> $past(state == ST_FIN))
  `C8IC_ASSERT_NEXT(a_block_loops, (state == ST_BLK_WR) && (cnt != fx), state == ST_BLK_RD)
  `C8IC_ASSERT(a_no_take_while_clearing, !pm_ready |-> !s_axis_tready)

endmodule

/* rtl/c8ic_pmem.sv */
// Program memory with font preload sweep after reset
`timescale 1ns / 1ps
module c8ic_pmem (
  input  logic              clk,
  input  logic              rst,
  input  c8ic_pkg::pm_req_t req,
  output logic [7:0]        rdata,
  output logic              ready
);
  import c8ic_pkg::*;

  logic [7:0]        mem [MEM_DEPTH];
  logic              clearing;
  logic [MEM_AW-1:0] clr_addr;
  logic              we;
  logic [MEM_AW-1:0] wa;
  logic [7:0]        wd;

  assign ready = !clearing;

  always_comb begin
    if (clearing) begin
      we = 1'b1;
      wa = clr_addr;
      wd = (clr_addr < MEM_AW'(FONT_LEN)) ? FONT[clr_addr[6:0]] : 8'h00;
    end else begin
      we = req.we;
      wa = req.waddr;
      wd = req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + MEM_AW'(1);
      if (clr_addr == MEM_AW'(MEM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[req.raddr];
  end

endmodule

/* rtl/c8ic_rf.sv */
// Register file: V0..VF followed by the return stack, one write and one read port
`timescale 1ns / 1ps
module c8ic_rf #(
  parameter int STACK_DEPTH = c8ic_pkg::STACK_DEPTH_DEFAULT,
  localparam int RF_DEPTH   = 16 + STACK_DEPTH,
  localparam int RF_AW      = $clog2(RF_DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [RF_AW-1:0] waddr,
  input  logic [11:0]      wdata,
  input  logic [RF_AW-1:0] raddr,
  output logic [11:0]      rdata
);

  logic [11:0]         mem [RF_DEPTH];
  logic [RF_DEPTH-1:0] valid;

  // Entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= valid[raddr] ? mem[raddr] : 12'h000;
  end

endmodule
